### src/cvq_pkg.sv
// Package for the compacting verdict queue: field widths, request codes and sequencer states.
package cvq_pkg;

    localparam int REQ_W   = 2;
    localparam int QID_W   = 4;
    localparam int LEN_W   = 7;
    localparam int WORD_W  = 32;
    localparam int INDEX_W = 6;
    localparam int TIME_W  = 31;
    localparam int MIN_LEN = 2;

    localparam logic [REQ_W-1:0] REQ_SET_LEN = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CHECK   = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SET,
        S_WR_PREV,
        S_WR_CUR,
        S_WR_STORE,
        S_MOD,
        S_CHK_START,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DONE
    } t_state;

endpackage

### src/cvq_store.sv
// Entry store memory: one write port, one read port with registered read data.
module cvq_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [cvq_pkg::WORD_W-1:0]   i_wdata,
    input  logic [AW-1:0]                i_raddr,
    output logic [cvq_pkg::WORD_W-1:0]   o_rdata
);

    logic [cvq_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [cvq_pkg::WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/cvq_cmp_unit.sv
// Shared subtract and compare unit used for index reduction and time search.
module cvq_cmp_unit #(
    parameter int W = 31
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic         o_ge,
    output logic [W-1:0] o_diff
);

    logic [W:0] w_sub;

    assign w_sub  = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge   = ~w_sub[W];
    assign o_diff = w_sub[W-1:0];

endmodule

### src/compacting_verdict_queue_unit.sv
// Top level of the compacting verdict queue: sequencer, queue pointers and result register.
//
//  channel | valid       | ready       | fields
//  in      | i_in_valid  | o_in_ready  | i_req_type i_queue_id i_queue_length i_entry_word
//          |             |             | i_read_index i_target_time
//  out     | o_out_valid | i_out_ready | o_found o_result_word o_read_index_out
//
// Set length: one update of the queue length, then the result. Write: two reads, one write of the store.
// Check: (read_index / length) reduction steps, then one store read per slot scanned,
// at most length - 1 slots.
// After reset the store is zeroed one word a cycle, all NUM_QUEUES*QUEUE_DEPTH words, not ready.
// A finished word waits in the output register; the next item is taken meanwhile.
module compacting_verdict_queue_unit #(
    parameter int NUM_QUEUES  = 16,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [cvq_pkg::REQ_W-1:0]      i_req_type,
    input  logic [cvq_pkg::QID_W-1:0]      i_queue_id,
    input  logic [cvq_pkg::LEN_W-1:0]      i_queue_length,
    input  logic [cvq_pkg::WORD_W-1:0]     i_entry_word,
    input  logic [cvq_pkg::INDEX_W-1:0]    i_read_index,
    input  logic [cvq_pkg::TIME_W-1:0]     i_target_time,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_found,
    output logic [cvq_pkg::WORD_W-1:0]     o_result_word,
    output logic [cvq_pkg::INDEX_W-1:0]    o_read_index_out
);

    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int LW    = $clog2(QUEUE_DEPTH + 1);
    localparam int IW    = (PW > cvq_pkg::INDEX_W) ? PW : cvq_pkg::INDEX_W;
    localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int QIW   = (QW > cvq_pkg::QID_W) ? QW : cvq_pkg::QID_W;
    localparam int CW    = (LW > cvq_pkg::LEN_W) ? LW : cvq_pkg::LEN_W;
    localparam int TOTAL = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW    = $clog2(TOTAL);
    localparam int UW    = cvq_pkg::TIME_W;

    localparam logic [AW-1:0] DEPTH_A   = AW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TOTAL - 1);
    localparam logic [LW-1:0] FULL_LEN  = LW'(QUEUE_DEPTH);

    cvq_pkg::t_state r_state, n_state;

    logic [PW-1:0]                  r_wp   [NUM_QUEUES];
    logic [LW-1:0]                  r_qlen [NUM_QUEUES];
    logic [AW-1:0]                  r_clr;

    logic [QIW-1:0]                 r_q;
    logic [cvq_pkg::LEN_W-1:0]      r_len_in;
    logic [cvq_pkg::WORD_W-1:0]     r_word;
    logic [IW-1:0]                  r_rd;
    logic [cvq_pkg::TIME_W-1:0]     r_target;
    logic [PW-1:0]                  r_ptr;
    logic [cvq_pkg::WORD_W-1:0]     r_pv;
    logic                           r_found;
    logic [cvq_pkg::WORD_W-1:0]     r_rword;
    logic [cvq_pkg::INDEX_W-1:0]    r_rout;

    logic                           r_o_valid;
    logic                           r_o_found;
    logic [cvq_pkg::WORD_W-1:0]     r_o_word;
    logic [cvq_pkg::INDEX_W-1:0]    r_o_rd;

    logic                           w_accept;
    logic                           w_qid_ok;
    logic                           w_out_free;
    logic [QW-1:0]                  w_qi;
    logic [PW-1:0]                  w_wp;
    logic [LW-1:0]                  w_len;
    logic [PW-1:0]                  w_prev;
    logic                           w_merge;
    logic [PW-1:0]                  w_dest;
    logic [LW-1:0]                  w_dest_inc;
    logic [PW-1:0]                  w_new_wp;
    logic [LW-1:0]                  w_ptr_inc;
    logic [PW-1:0]                  w_next_ptr;
    logic [CW-1:0]                  w_len_ext;
    logic [LW-1:0]                  w_new_len;

    logic                           w_we;
    logic [AW-1:0]                  w_waddr;
    logic [cvq_pkg::WORD_W-1:0]     w_wdata;
    logic [AW-1:0]                  w_raddr;
    logic [cvq_pkg::WORD_W-1:0]     w_rdata;

    logic [UW-1:0]                  w_ua;
    logic [UW-1:0]                  w_ub;
    logic                           w_uge;
    logic [UW-1:0]                  w_udiff;

    function automatic logic [AW-1:0] slot(input logic [QW-1:0] q, input logic [PW-1:0] s);
        return AW'(q) * DEPTH_A + AW'(s);
    endfunction

    cvq_store #(
        .DEPTH (TOTAL),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    cvq_cmp_unit #(
        .W (UW)
    ) u_cmp (
        .i_a    (w_ua),
        .i_b    (w_ub),
        .o_ge   (w_uge),
        .o_diff (w_udiff)
    );

    assign o_in_ready = (r_state == cvq_pkg::S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_qid_ok   = int'(i_queue_id) < NUM_QUEUES;
    assign w_out_free = !r_o_valid || i_out_ready;

    assign w_qi  = r_q[QW-1:0];
    assign w_wp  = r_wp[w_qi];
    assign w_len = r_qlen[w_qi];

    assign w_prev     = (w_wp == '0) ? PW'(w_len - LW'(1)) : w_wp - PW'(1);
    assign w_merge    = (r_pv[cvq_pkg::WORD_W-1] == r_word[cvq_pkg::WORD_W-1])
                        && (r_pv != w_rdata);
    assign w_dest     = w_merge ? w_prev : w_wp;
    assign w_dest_inc = LW'(w_dest) + LW'(1);
    assign w_new_wp   = (w_dest_inc >= w_len) ? '0 : PW'(w_dest_inc);

    assign w_ptr_inc  = LW'(r_ptr) + LW'(1);
    assign w_next_ptr = (w_ptr_inc >= w_len) ? '0 : PW'(w_ptr_inc);

    assign w_len_ext  = CW'(r_len_in);

    always_comb begin
        priority if (w_len_ext < CW'(cvq_pkg::MIN_LEN)) begin
            w_new_len = LW'(cvq_pkg::MIN_LEN);
        end else if (w_len_ext > CW'(QUEUE_DEPTH)) begin
            w_new_len = FULL_LEN;
        end else begin
            w_new_len = LW'(w_len_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cvq_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_we    = 1'b0;
        w_waddr = slot(w_qi, w_dest);
        w_wdata = r_word;
        w_raddr = slot(w_qi, r_ptr);
        w_ua    = '0;
        w_ub    = '0;
        unique case (r_state)
            cvq_pkg::S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                if (r_clr == LAST_ADDR) begin
                    n_state = cvq_pkg::S_IDLE;
                end
            end
            cvq_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (!w_qid_ok) begin
                        n_state = cvq_pkg::S_DONE;
                    end else begin
                        priority case (i_req_type)
                            cvq_pkg::REQ_SET_LEN: n_state = cvq_pkg::S_SET;
                            cvq_pkg::REQ_WRITE:   n_state = cvq_pkg::S_WR_PREV;
                            cvq_pkg::REQ_CHECK:   n_state = cvq_pkg::S_MOD;
                            default:              n_state = cvq_pkg::S_DONE;
                        endcase
                    end
                end
            end
            cvq_pkg::S_SET: begin
                n_state = cvq_pkg::S_DONE;
            end
            cvq_pkg::S_WR_PREV: begin
                w_raddr = slot(w_qi, w_prev);
                n_state = cvq_pkg::S_WR_CUR;
            end
            cvq_pkg::S_WR_CUR: begin
                w_raddr = slot(w_qi, w_wp);
                n_state = cvq_pkg::S_WR_STORE;
            end
            cvq_pkg::S_WR_STORE: begin
                w_we    = 1'b1;
                n_state = cvq_pkg::S_DONE;
            end
            cvq_pkg::S_MOD: begin
                w_ua = UW'(r_rd);
                w_ub = UW'(w_len);
                if (!w_uge) begin
                    n_state = cvq_pkg::S_CHK_START;
                end
            end
            cvq_pkg::S_CHK_START: begin
                n_state = (r_ptr == w_wp) ? cvq_pkg::S_DONE : cvq_pkg::S_SCAN_RD;
            end
            cvq_pkg::S_SCAN_RD: begin
                n_state = cvq_pkg::S_SCAN_CMP;
            end
            cvq_pkg::S_SCAN_CMP: begin
                w_ua = w_rdata[cvq_pkg::TIME_W-1:0];
                w_ub = r_target;
                if (w_uge || (w_next_ptr == w_wp)) begin
                    n_state = cvq_pkg::S_DONE;
                end else begin
                    n_state = cvq_pkg::S_SCAN_RD;
                end
            end
            cvq_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = cvq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cvq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_wp[i]   <= '0;
                r_qlen[i] <= FULL_LEN;
            end
        end else begin
            if (r_state == cvq_pkg::S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (r_state == cvq_pkg::S_SET) begin
                r_qlen[w_qi] <= w_new_len;
                if (LW'(w_wp) >= w_new_len) begin
                    r_wp[w_qi] <= '0;
                end
            end
            if (r_state == cvq_pkg::S_WR_STORE) begin
                r_wp[w_qi] <= w_new_wp;
            end
            if (r_state == cvq_pkg::S_DONE && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            cvq_pkg::S_IDLE: begin
                if (w_accept) begin
                    r_q      <= QIW'(i_queue_id);
                    r_len_in <= i_queue_length;
                    r_word   <= i_entry_word;
                    r_rd     <= IW'(i_read_index);
                    r_target <= i_target_time;
                    r_found  <= 1'b0;
                    r_rword  <= '0;
                    r_rout   <= (!w_qid_ok && i_req_type == cvq_pkg::REQ_CHECK)
                                ? i_read_index : '0;
                end
            end
            cvq_pkg::S_WR_CUR: begin
                r_pv <= w_rdata;
            end
            cvq_pkg::S_MOD: begin
                if (w_uge) begin
                    r_rd <= IW'(w_udiff);
                end else begin
                    r_ptr <= PW'(r_rd);
                end
            end
            cvq_pkg::S_CHK_START: begin
                r_rout <= cvq_pkg::INDEX_W'(r_ptr);
            end
            cvq_pkg::S_SCAN_CMP: begin
                if (w_uge) begin
                    r_found <= 1'b1;
                    r_rword <= w_rdata;
                    r_rout  <= cvq_pkg::INDEX_W'(r_ptr);
                end else if (w_next_ptr == w_wp) begin
                    r_rout  <= cvq_pkg::INDEX_W'(r_ptr);
                end else begin
                    r_ptr   <= w_next_ptr;
                end
            end
            cvq_pkg::S_DONE: begin
                if (w_out_free) begin
                    r_o_found <= r_found;
                    r_o_word  <= r_rword;
                    r_o_rd    <= r_rout;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid      = r_o_valid;
    assign o_found          = r_o_found;
    assign o_result_word    = r_o_word;
    assign o_read_index_out = r_o_rd;

endmodule

### src/cvq_checker.sv
// Port-level checker for the compacting verdict queue, bound to the top level.
module cvq_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_ready,
    input  logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  logic                           o_found,
    input  logic [cvq_pkg::WORD_W-1:0]     o_result_word,
    input  logic [cvq_pkg::INDEX_W-1:0]    o_read_index_out
);

    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready
    ) else $error("ready stayed high after a word was accepted");

    a_not_found_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_result_word == '0)
    ) else $error("result word nonzero without found");

    a_out_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_result_word) && $stable(o_read_index_out)
             && $stable(o_found))
    ) else $error("stalled result word changed");

    a_reset_quiet: assert property (
        @(posedge i_clk)
        !i_rst_n |=> (!o_in_ready && !o_out_valid)
    ) else $error("block active right after reset");

endmodule

bind compacting_verdict_queue_unit cvq_checker u_cvq_checker (.*);
